// ===== rtl/core/pls_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pls_pkg: shared definitions for the periodic Laplacian stencil unit
// Default grid shape, datapath widths, tap codes and controller/datapath
// command and status structures.
// ----------------------------------------------------------------------------
package pls_pkg;

	localparam int DEF_SIZE_X     = 16;
	localparam int DEF_SIZE_Y     = 16;
	localparam int DEF_SIZE_Z     = 16;
	localparam int DEF_COMPONENTS = 3;

	localparam int DATA_W  = 32;
	localparam int COORD_W = 4;
	localparam int COMP_W  = 2;
	localparam int ACC_W   = 36;
	localparam int MOP_W   = 19;
	localparam int PROD_W  = 51;
	localparam int FULL_W  = 69;
	localparam int TAP_W   = 3;

	localparam logic MODE_WRITE   = 1'b0;
	localparam logic MODE_COMPUTE = 1'b1;

	localparam logic [TAP_W-1:0] TAP_C  = 3'd0;
	localparam logic [TAP_W-1:0] TAP_XM = 3'd1;
	localparam logic [TAP_W-1:0] TAP_XP = 3'd2;
	localparam logic [TAP_W-1:0] TAP_YM = 3'd3;
	localparam logic [TAP_W-1:0] TAP_YP = 3'd4;
	localparam logic [TAP_W-1:0] TAP_ZM = 3'd5;
	localparam logic [TAP_W-1:0] TAP_ZP = 3'd6;

	typedef struct packed {
		logic             load;
		logic             rd_en;
		logic             wr_en;
		logic [TAP_W-1:0] tap;
		logic             mul_lo;
		logic             mul_hi;
		logic             sum;
		logic             out_load;
		logic             out_zero;
	} pls_cmd_t;

	typedef struct packed {
		logic comp_ok;
	} pls_sts_t;

	// reduce a 4-bit coordinate modulo an axis size of at least 4
	function automatic logic [COORD_W-1:0] wrap_coord(input logic [COORD_W-1:0] v,
			input int size);
		logic [8:0] t;
		t = {5'd0, v};
		for (int i = 0; i < 4; i++) begin
			if (t >= 9'(size)) begin
				t = t - 9'(size);
			end
		end
		return t[COORD_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/pls_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pls_ctrl: sequencer of the stencil unit
// Accepts items; for a compute, steps the seven stencil reads, drain, two-pass
// multiply, rounding sum and result load, else a grid write or a zero result.
// ----------------------------------------------------------------------------
module pls_ctrl
	import pls_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire logic     mode,
	input  wire pls_sts_t sts,
	output logic          busy,
	output pls_cmd_t      cmd
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_COMP = 4'd1;
	localparam logic [3:0] ST_DR1  = 4'd2;
	localparam logic [3:0] ST_DR2  = 4'd3;
	localparam logic [3:0] ST_MLO  = 4'd4;
	localparam logic [3:0] ST_MHI  = 4'd5;
	localparam logic [3:0] ST_SUM  = 4'd6;
	localparam logic [3:0] ST_OUT  = 4'd7;
	localparam logic [3:0] ST_WR   = 4'd8;
	localparam logic [3:0] ST_ZERO = 4'd9;

	logic [3:0]       state_q, state_d;
	logic [TAP_W-1:0] tap_q, tap_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tap_q   <= TAP_C;
		end else begin
			state_q <= state_d;
			tap_q   <= tap_d;
		end
	end

	always_comb begin
		cmd     = '0;
		cmd.tap = tap_q;
		state_d = state_q;
		tap_d   = tap_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					tap_d    = TAP_C;
					if (mode == MODE_COMPUTE) begin
						state_d = sts.comp_ok ? ST_COMP : ST_ZERO;
					end else if (sts.comp_ok) begin
						state_d = ST_WR;
					end
				end
			end
			ST_COMP: begin
				cmd.rd_en = 1'b1;
				if (tap_q == TAP_ZP) begin
					state_d = ST_DR1;
				end else begin
					tap_d = tap_q + 3'd1;
				end
			end
			ST_DR1: state_d = ST_DR2;
			ST_DR2: state_d = ST_MLO;
			ST_MLO: begin
				cmd.mul_lo = 1'b1;
				state_d    = ST_MHI;
			end
			ST_MHI: begin
				cmd.mul_hi = 1'b1;
				state_d    = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				cmd.out_load = 1'b1;
				state_d      = ST_IDLE;
			end
			ST_WR: begin
				cmd.wr_en = 1'b1;
				cmd.tap   = TAP_C;
				state_d   = ST_IDLE;
			end
			ST_ZERO: begin
				cmd.out_zero = 1'b1;
				state_d      = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule
`default_nettype wire

// ===== rtl/core/pls_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pls_dp: datapath of the stencil unit
// Item registers, periodic neighbour addressing, single-port grid memory,
// stencil accumulator, shared 19x32 multiplier, rounding and saturation.
// ----------------------------------------------------------------------------
module pls_dp
	import pls_pkg::*;
#(
	parameter int SIZE_X     = DEF_SIZE_X,
	parameter int SIZE_Y     = DEF_SIZE_Y,
	parameter int SIZE_Z     = DEF_SIZE_Z,
	parameter int COMPONENTS = DEF_COMPONENTS
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire pls_cmd_t                 cmd,
	output pls_sts_t                      sts,
	input  wire logic [COORD_W-1:0]       pos_x,
	input  wire logic [COORD_W-1:0]       pos_y,
	input  wire logic [COORD_W-1:0]       pos_z,
	input  wire logic [COMP_W-1:0]        component,
	input  wire logic signed [DATA_W-1:0] write_value,
	input  wire logic signed [DATA_W-1:0] scale_factor,
	output logic                          done,
	output logic signed [DATA_W-1:0]      term_value,
	output logic                          saturated
);

	localparam int XW       = $clog2(SIZE_X);
	localparam int YW       = $clog2(SIZE_Y);
	localparam int ZW       = $clog2(SIZE_Z);
	localparam int DEPTH    = SIZE_X * SIZE_Y * SIZE_Z * COMPONENTS;
	localparam int AW       = $clog2(DEPTH);
	localparam int STRIDE_Z = COMPONENTS;
	localparam int STRIDE_Y = SIZE_Z * COMPONENTS;
	localparam int STRIDE_X = SIZE_Y * SIZE_Z * COMPONENTS;

	logic [XW-1:0]              x_q, xm, xp, sx;
	logic [YW-1:0]              y_q, ym, yp, sy;
	logic [ZW-1:0]              z_q, zm, zp, sz;
	logic [XW:0]                x_t;
	logic [YW:0]                y_t;
	logic [ZW:0]                z_t;
	logic [COMP_W-1:0]          c_q;
	logic signed [DATA_W-1:0]   wdata_q;
	logic [AW-1:0]              addr;

	logic [AW-1:0]              addr_s1;
	logic [TAP_W-1:0]           tap_s1;
	logic                       rd_s1;
	logic                       we_s1;
	logic signed [DATA_W-1:0]   rdata_s2;
	logic [TAP_W-1:0]           tap_s2;
	logic                       rd_s2;
	logic signed [DATA_W-1:0]   mem [DEPTH];

	logic signed [ACC_W-1:0]    acc_q, rd_ext;
	logic signed [MOP_W-1:0]    mop;
	logic signed [PROD_W-1:0]   prod, prod_q, plo_q;
	logic signed [FULL_W-1:0]   full_q;
	logic [21:0]                top_bits;

	logic                       done_q, sat_q;
	logic signed [DATA_W-1:0]   term_q;

	assign sts.comp_ok = (component < 2'(COMPONENTS));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q     <= XW'(wrap_coord(pos_x, SIZE_X));
			y_q     <= YW'(wrap_coord(pos_y, SIZE_Y));
			z_q     <= ZW'(wrap_coord(pos_z, SIZE_Z));
			c_q     <= component;
			wdata_q <= write_value;
		end
	end

	// periodic neighbours at distance two
	always_comb begin
		xm  = (x_q >= XW'(2)) ? x_q - XW'(2) : x_q + XW'(SIZE_X - 2);
		x_t = {1'b0, x_q} + (XW+1)'(2);
		xp  = (x_t >= (XW+1)'(SIZE_X)) ? XW'(x_t - (XW+1)'(SIZE_X)) : XW'(x_t);
		ym  = (y_q >= YW'(2)) ? y_q - YW'(2) : y_q + YW'(SIZE_Y - 2);
		y_t = {1'b0, y_q} + (YW+1)'(2);
		yp  = (y_t >= (YW+1)'(SIZE_Y)) ? YW'(y_t - (YW+1)'(SIZE_Y)) : YW'(y_t);
		zm  = (z_q >= ZW'(2)) ? z_q - ZW'(2) : z_q + ZW'(SIZE_Z - 2);
		z_t = {1'b0, z_q} + (ZW+1)'(2);
		zp  = (z_t >= (ZW+1)'(SIZE_Z)) ? ZW'(z_t - (ZW+1)'(SIZE_Z)) : ZW'(z_t);
	end

	always_comb begin
		sx = x_q;
		sy = y_q;
		sz = z_q;
		case (cmd.tap)
			TAP_C:  ;
			TAP_XM: sx = xm;
			TAP_XP: sx = xp;
			TAP_YM: sy = ym;
			TAP_YP: sy = yp;
			TAP_ZM: sz = zm;
			TAP_ZP: sz = zp;
			default: ;
		endcase
		addr = AW'(sx) * AW'(STRIDE_X) + AW'(sy) * AW'(STRIDE_Y)
			+ AW'(sz) * AW'(STRIDE_Z) + AW'(c_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
			we_s1 <= 1'b0;
			rd_s2 <= 1'b0;
		end else begin
			rd_s1 <= cmd.rd_en;
			we_s1 <= cmd.wr_en;
			rd_s2 <= rd_s1;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr;
		tap_s1  <= cmd.tap;
		tap_s2  <= tap_s1;
	end

	always_ff @(posedge clk) begin
		if (we_s1) begin
			mem[addr_s1] <= wdata_q;
		end
	end

	always_ff @(posedge clk) begin
		rdata_s2 <= mem[addr_s1];
	end

	// 6*centre minus the six neighbours
	assign rd_ext = ACC_W'(rdata_s2);

	always_ff @(posedge clk) begin
		if (rd_s2) begin
			if (tap_s2 == TAP_C) begin
				acc_q <= (rd_ext <<< 2) + (rd_ext <<< 1);
			end else begin
				acc_q <= acc_q - rd_ext;
			end
		end
	end

	// shared multiplier: low 18 bits unsigned, then high 18 bits signed
	assign mop  = cmd.mul_hi ? MOP_W'($signed(acc_q[ACC_W-1:18]))
		: $signed({1'b0, acc_q[17:0]});
	assign prod = mop * scale_factor;

	always_ff @(posedge clk) begin
		if (cmd.mul_lo) begin
			prod_q <= prod;
		end
		if (cmd.mul_hi) begin
			prod_q <= prod;
			plo_q  <= prod_q;
		end
		if (cmd.sum) begin
			full_q <= $signed({prod_q, 18'd0}) + FULL_W'(plo_q) + FULL_W'(32768);
		end
	end

	assign top_bits = full_q[FULL_W-1:47];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.out_load | cmd.out_zero;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_zero) begin
			term_q <= '0;
			sat_q  <= 1'b0;
		end else if (cmd.out_load) begin
			if ((&top_bits) || !(|top_bits)) begin
				term_q <= full_q[47:16];
				sat_q  <= 1'b0;
			end else begin
				term_q <= full_q[FULL_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
					: {1'b0, {(DATA_W-1){1'b1}}};
				sat_q  <= 1'b1;
			end
		end
	end

	assign done       = done_q;
	assign term_value = term_q;
	assign saturated  = sat_q;

endmodule
`default_nettype wire

// ===== rtl/core/periodic_laplacian_stencil_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_laplacian_stencil_unit: periodic 3D seven-point Laplacian term
// Stores a Q16.16 vector grid and returns scale_factor times
// (6*centre - neighbours at distance two), rounded and saturated.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy low. A write item holds busy
// for one cycle; the value is written to the grid memory from the registered
// write enable and address, in time for any following read. A compute item
// steps to the next possible accept through seven reads on the single grid
// memory port, two read and accumulate drain states, two passes of a shared
// 19x32 multiplier, one rounding add and the saturating result load. A compute
// on a component past the configured count returns zero. Each result beat is
// shown for one cycle with done high and cannot be held off; it appears in the
// cycle in which the next item may be taken. The grid is not cleared at reset:
// read only entries already written. scale_factor sits at byte address 0; the
// user must write it only while idle, as the block does not enforce it.
// ----------------------------------------------------------------------------
module periodic_laplacian_stencil_unit
	import pls_pkg::*;
#(
	parameter int SIZE_X     = DEF_SIZE_X,
	parameter int SIZE_Y     = DEF_SIZE_Y,
	parameter int SIZE_Z     = DEF_SIZE_Z,
	parameter int COMPONENTS = DEF_COMPONENTS
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [2:0]               paddr,
	input  wire logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]             prdata,
	output logic                          pready,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic                     mode,
	input  wire logic [COORD_W-1:0]       pos_x,
	input  wire logic [COORD_W-1:0]       pos_y,
	input  wire logic [COORD_W-1:0]       pos_z,
	input  wire logic [COMP_W-1:0]        component,
	input  wire logic signed [DATA_W-1:0] write_value,
	output logic                          done,
	output logic signed [DATA_W-1:0]      term_value,
	output logic                          saturated
);

	logic signed [DATA_W-1:0] scale_q;
	pls_cmd_t                 cmd;
	pls_sts_t                 sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= '0;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			scale_q <= pwdata;
		end
	end

	assign prdata = paddr[2] ? '0 : scale_q;

	pls_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	pls_dp #(
		.SIZE_X     (SIZE_X),
		.SIZE_Y     (SIZE_Y),
		.SIZE_Z     (SIZE_Z),
		.COMPONENTS (COMPONENTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.component    (component),
		.write_value  (write_value),
		.scale_factor (scale_q),
		.done         (done),
		.term_value   (term_value),
		.saturated    (saturated)
	);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode == MODE_COMPUTE) |=> busy)
		else $error("compute item did not start");

	a_single_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result beats back to back");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && mode == MODE_WRITE) |=> !done)
		else $error("write item produced a result");

endmodule
`default_nettype wire
